// ----- rtl/core/eitp_pkg.sv -----
// ----------------------------------------------------------------------------
// eitp_pkg: shared types and constants of the event information parser
// Beat structs, phase and record kind codes, and the fixed section layout.
// ----------------------------------------------------------------------------
package eitp_pkg;

    // parse phase of the current section
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_HEAD  = 3'd1,
        PH_EVENT = 3'd2,
        PH_DESC  = 3'd3,
        PH_CRC   = 3'd4
    } t_phase;

    // record kind codes carried in record_kind
    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_EVENT  = 2'd1,
        KIND_END    = 2'd2,
        KIND_BAD_ID = 2'd3
    } t_kind;

    // accepted table ids
    localparam logic [7:0] TID_PF_ACTUAL  = 8'h4E;
    localparam logic [7:0] TID_PF_OTHER   = 8'h4F;
    localparam logic [7:0] TID_SCHED_LOW  = 8'h50;
    localparam logic [7:0] TID_SCHED_HIGH = 8'h6F;

    // section layout
    localparam int unsigned HEAD_BYTES  = 14;
    localparam int unsigned EVENT_BYTES = 12;
    localparam logic [3:0]  HEAD_LAST   = 4'd13;
    localparam logic [3:0]  EVENT_LAST  = 4'd11;
    localparam logic [3:0]  EVENT_DEPTH = 4'd12;
    localparam logic [3:0]  CRC_LAST    = 4'd3;
    localparam logic [11:0] LEN_OFFSET  = 12'd11;
    localparam logic [11:0] CRC_BYTES   = 12'd4;
    localparam logic [12:0] EVENT_USED  = 13'd12;

    // input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic [1:0]  record_kind;
        logic [15:0] ident;
        logic [4:0]  version;
        logic [7:0]  section_index;
        logic [15:0] stream_ident;
        logic [15:0] network_ident;
        logic [15:0] start_day;
        logic [23:0] start_clock;
        logic [23:0] length_clock;
        logic [2:0]  run_state;
        logic        conditional_access;
        logic [31:0] check_word;
    } t_out_beat;

    // command from the input register to the engine
    typedef struct packed {
        logic     go;
        t_in_beat beat;
    } t_eng_cmd;

    // result from the engine to the output register
    typedef struct packed {
        logic      valid;
        t_out_beat beat;
    } t_eng_res;

endpackage

// ----- rtl/core/eit_section_event_parser.sv -----
// ----------------------------------------------------------------------------
// eit_section_event_parser: event information section parser
// Parses section bytes into header, event, section end and bad id records.
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+----------------------------
//   in      | i_in_valid | o_in_stall  | i_in_beat  (one section byte)
//   out     | o_out_valid| i_out_stall | o_out_beat (one record)
//
// One byte beat per cycle while the input is not stalled. A record passes
// through the input register, one pass of the parse engine and the output
// register. Reset is synchronous and active low and returns the parser to
// waiting for a section start. A stall on the output holds the output register
// and then the input register, which stalls the input.
// ----------------------------------------------------------------------------
module eit_section_event_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  eitp_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output eitp_pkg::t_out_beat o_out_beat
);

    logic                r_in_valid;
    eitp_pkg::t_in_beat  r_in_beat;
    logic                r_out_valid;
    eitp_pkg::t_out_beat r_out_beat;
    logic                out_open;
    eitp_pkg::t_eng_cmd  cmd;
    eitp_pkg::t_eng_res  res;

    // handshake between the two registers
    assign out_open   = !r_out_valid || !i_out_stall;
    assign cmd.go     = r_in_valid && out_open;
    assign cmd.beat   = r_in_beat;
    assign o_in_stall = r_in_valid && !out_open;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_beat <= i_in_beat;
        end
    end

    // parse engine
    eitp_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_res   (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_open) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_open && res.valid) begin
            r_out_beat <= res.beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

`ifndef SYNTHESIS
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall))
        else $error("input stalled without a held output beat");
    a_res_needs_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |-> cmd.go)
        else $error("record produced without a byte beat");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_beat)))
        else $error("stalled output beat changed");
`endif

endmodule

// ----- rtl/core/eitp_engine.sv -----
// ----------------------------------------------------------------------------
// eitp_engine: section parse state and record extraction
// Tracks the section phase, stores header and event bytes and builds records.
// ----------------------------------------------------------------------------
module eitp_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  eitp_pkg::t_eng_cmd  i_cmd,
    output eitp_pkg::t_eng_res  o_res
);

    eitp_pkg::t_phase r_phase, n_phase;
    logic [3:0]       r_count, n_count;
    logic [11:0]      r_rem, n_rem;
    logic [11:0]      r_desc, n_desc;
    logic [31:0]      r_check, n_check;

    // byte stores, written before read within a section
    logic [7:0] r_head [eitp_pkg::HEAD_BYTES];
    logic [7:0] r_evt  [eitp_pkg::EVENT_BYTES];

    logic       head_we, evt_we;
    logic [3:0] head_idx, evt_idx;
    logic [7:0] b;
    logic [11:0] slen, dll, rem_new, desc_dec;
    logic [12:0] used;

    assign b        = i_cmd.beat.data_byte;
    assign evt_idx  = (r_count < eitp_pkg::EVENT_DEPTH) ? r_count : 4'd0;
    assign slen     = {r_head[1][3:0], r_head[2]};
    assign dll      = {r_evt[10][3:0], b};
    assign used     = {1'b0, dll} + eitp_pkg::EVENT_USED;
    assign desc_dec = (r_desc != 12'd0) ? (r_desc - 12'd1) : r_desc;

    // next state and record
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_rem    = r_rem;
        n_desc   = r_desc;
        n_check  = r_check;
        head_we  = 1'b0;
        evt_we   = 1'b0;
        head_idx = r_count;
        rem_new  = r_rem;
        o_res    = '0;
        if (i_cmd.beat.first_byte) begin
            if (b inside {eitp_pkg::TID_PF_ACTUAL, eitp_pkg::TID_PF_OTHER,
                          [eitp_pkg::TID_SCHED_LOW:eitp_pkg::TID_SCHED_HIGH]}) begin
                head_we  = 1'b1;
                head_idx = 4'd0;
                n_count  = 4'd1;
                n_phase  = eitp_pkg::PH_HEAD;
            end else begin
                n_phase = eitp_pkg::PH_IDLE;
                n_count = 4'd0;
                o_res.valid = 1'b1;
                o_res.beat.record_kind = eitp_pkg::KIND_BAD_ID;
            end
        end else begin
            case (r_phase)
                eitp_pkg::PH_HEAD: begin
                    head_we = 1'b1;
                    n_count = r_count + 4'd1;
                    if (r_count == eitp_pkg::HEAD_LAST) begin
                        rem_new = (slen > eitp_pkg::LEN_OFFSET) ?
                                  (slen - eitp_pkg::LEN_OFFSET) : 12'd0;
                        n_rem   = rem_new;
                        n_count = 4'd0;
                        n_check = '0;
                        n_phase = (rem_new > eitp_pkg::CRC_BYTES) ?
                                  eitp_pkg::PH_EVENT : eitp_pkg::PH_CRC;
                        o_res.valid = 1'b1;
                        o_res.beat.record_kind   = eitp_pkg::KIND_HEADER;
                        o_res.beat.ident         = {r_head[3], r_head[4]};
                        o_res.beat.version       = r_head[5][5:1];
                        o_res.beat.section_index = r_head[6];
                        o_res.beat.stream_ident  = {r_head[8], r_head[9]};
                        o_res.beat.network_ident = {r_head[10], r_head[11]};
                    end
                end
                eitp_pkg::PH_EVENT: begin
                    evt_we  = 1'b1;
                    n_count = r_count + 4'd1;
                    if (r_count == eitp_pkg::EVENT_LAST) begin
                        rem_new = ({1'b0, r_rem} > used) ? (r_rem - used[11:0]) : 12'd0;
                        n_rem   = rem_new;
                        n_desc  = dll;
                        n_count = 4'd0;
                        if (dll != 12'd0) begin
                            n_phase = eitp_pkg::PH_DESC;
                        end else begin
                            n_check = '0;
                            n_phase = (rem_new > eitp_pkg::CRC_BYTES) ?
                                      eitp_pkg::PH_EVENT : eitp_pkg::PH_CRC;
                        end
                        o_res.valid = 1'b1;
                        o_res.beat.record_kind        = eitp_pkg::KIND_EVENT;
                        o_res.beat.ident              = {r_evt[0], r_evt[1]};
                        o_res.beat.start_day          = {r_evt[2], r_evt[3]};
                        o_res.beat.start_clock        = {r_evt[4], r_evt[5], r_evt[6]};
                        o_res.beat.length_clock       = {r_evt[7], r_evt[8], r_evt[9]};
                        o_res.beat.run_state          = r_evt[10][7:5];
                        o_res.beat.conditional_access = r_evt[10][4];
                    end
                end
                eitp_pkg::PH_DESC: begin
                    n_desc = desc_dec;
                    if (desc_dec == 12'd0) begin
                        n_count = 4'd0;
                        n_check = '0;
                        n_phase = (r_rem > eitp_pkg::CRC_BYTES) ?
                                  eitp_pkg::PH_EVENT : eitp_pkg::PH_CRC;
                    end
                end
                eitp_pkg::PH_CRC: begin
                    n_check = {r_check[23:0], b};
                    n_count = r_count + 4'd1;
                    if (r_count == eitp_pkg::CRC_LAST) begin
                        n_phase = eitp_pkg::PH_IDLE;
                        n_count = 4'd0;
                        o_res.valid = 1'b1;
                        o_res.beat.record_kind = eitp_pkg::KIND_END;
                        o_res.beat.check_word  = n_check;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
        if (!i_cmd.go) begin
            o_res.valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= eitp_pkg::PH_IDLE;
            r_count <= '0;
            r_rem   <= '0;
            r_desc  <= '0;
            r_check <= '0;
        end else if (i_cmd.go) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_rem   <= n_rem;
            r_desc  <= n_desc;
            r_check <= n_check;
        end
    end

    // byte stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.go && head_we) begin
            r_head[head_idx] <= b;
        end
        if (i_cmd.go && evt_we) begin
            r_evt[evt_idx] <= b;
        end
    end

`ifndef SYNTHESIS
    a_desc_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == eitp_pkg::PH_DESC |-> r_desc != 12'd0)
        else $error("descriptor skip with nothing left");
    a_head_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == eitp_pkg::PH_HEAD |-> (r_count != 4'd0 && r_count <= eitp_pkg::HEAD_LAST))
        else $error("header byte count out of range");
    a_evt_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == eitp_pkg::PH_EVENT |-> r_count <= eitp_pkg::EVENT_LAST)
        else $error("event byte count out of range");
    a_crc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == eitp_pkg::PH_CRC |-> r_count <= eitp_pkg::CRC_LAST)
        else $error("crc byte count out of range");
`endif

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: regression for the event information section parser
// Feeds section bytes through the valid/stall input channel. A local parse
// model predicts every record, and each record beat is checked field by field.
// Runs directed sections for the corner cases, a long output hold-off and
// randomised section streams under several idle and stall mixes.
// ----------------------------------------------------------------------------
module testbench;

    localparam int QUIET_LIMIT  = 4000;
    localparam int RANDOM_BYTES = 1200;
    localparam int HOLD_CYCLES  = 300;
    localparam int DESC_CUT     = 64;

    // dut ports
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    eitp_pkg::t_in_beat  i_in_beat   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    eitp_pkg::t_out_beat o_out_beat;

    // parse model state
    eitp_pkg::t_phase sec_phase;
    logic [3:0]       sec_count;
    logic [11:0]      sec_remaining;
    logic [11:0]      desc_skip;
    logic [7:0]       head_bytes [eitp_pkg::HEAD_BYTES];
    logic [7:0]       event_bytes [eitp_pkg::EVENT_BYTES];
    logic [31:0]      crc_word;

    // predicted records, oldest first
    eitp_pkg::t_out_beat expected_records [$];

    // section under construction
    logic [7:0] sec_buf [$];

    // run control and bookkeeping
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_left      = 0;
    int errors         = 0;
    int bytes_sent     = 0;
    int records_seen   = 0;
    int kind_seen [4]  = '{0, 0, 0, 0};

    eit_section_event_parser DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit table_id_ok(input logic [7:0] tid);
        return (tid == eitp_pkg::TID_PF_ACTUAL) || (tid == eitp_pkg::TID_PF_OTHER) ||
               ((tid >= eitp_pkg::TID_SCHED_LOW) && (tid <= eitp_pkg::TID_SCHED_HIGH));
    endfunction

    // move on after an event or the header: next event or crc
    function automatic void close_event();
        sec_count = 4'd0;
        crc_word  = 32'd0;
        sec_phase = (sec_remaining > eitp_pkg::CRC_BYTES) ? eitp_pkg::PH_EVENT
                                                          : eitp_pkg::PH_CRC;
    endfunction

    // parse model, one accepted byte; returns 1 when a record is due
    function automatic bit parse_section_byte(input logic [7:0] b, input logic is_start,
                                              output eitp_pkg::t_out_beat rec);
        int unsigned slen;
        int unsigned dll;
        int unsigned used;
        rec = '0;
        if (is_start) begin
            if (!table_id_ok(b)) begin
                sec_phase = eitp_pkg::PH_IDLE;
                sec_count = 4'd0;
                rec.record_kind = eitp_pkg::KIND_BAD_ID;
                return 1'b1;
            end
            head_bytes[0] = b;
            sec_count = 4'd1;
            sec_phase = eitp_pkg::PH_HEAD;
            return 1'b0;
        end
        case (sec_phase)
            eitp_pkg::PH_HEAD: begin
                head_bytes[sec_count] = b;
                sec_count++;
                if (sec_count < eitp_pkg::HEAD_BYTES)
                    return 1'b0;
                slen = {head_bytes[1][3:0], head_bytes[2]};
                sec_remaining = (slen > eitp_pkg::LEN_OFFSET) ?
                                12'(slen - eitp_pkg::LEN_OFFSET) : 12'd0;
                close_event();
                rec.record_kind   = eitp_pkg::KIND_HEADER;
                rec.ident         = {head_bytes[3], head_bytes[4]};
                rec.version       = head_bytes[5][5:1];
                rec.section_index = head_bytes[6];
                rec.stream_ident  = {head_bytes[8], head_bytes[9]};
                rec.network_ident = {head_bytes[10], head_bytes[11]};
                return 1'b1;
            end
            eitp_pkg::PH_EVENT: begin
                event_bytes[(sec_count < eitp_pkg::EVENT_BYTES) ? sec_count : 4'd0] = b;
                sec_count++;
                if (sec_count < eitp_pkg::EVENT_BYTES)
                    return 1'b0;
                dll  = {event_bytes[10][3:0], event_bytes[11]};
                used = eitp_pkg::EVENT_BYTES + dll;
                // overrun saturates the remaining length
                sec_remaining = (sec_remaining > used) ? 12'(sec_remaining - used) : 12'd0;
                desc_skip = 12'(dll);
                if (dll > 0) begin
                    sec_phase = eitp_pkg::PH_DESC;
                    sec_count = 4'd0;
                end else begin
                    close_event();
                end
                rec.record_kind        = eitp_pkg::KIND_EVENT;
                rec.ident              = {event_bytes[0], event_bytes[1]};
                rec.start_day          = {event_bytes[2], event_bytes[3]};
                rec.start_clock        = {event_bytes[4], event_bytes[5], event_bytes[6]};
                rec.length_clock       = {event_bytes[7], event_bytes[8], event_bytes[9]};
                rec.run_state          = event_bytes[10][7:5];
                rec.conditional_access = event_bytes[10][4];
                return 1'b1;
            end
            eitp_pkg::PH_DESC: begin
                if (desc_skip > 0)
                    desc_skip--;
                if (desc_skip == 0)
                    close_event();
                return 1'b0;
            end
            eitp_pkg::PH_CRC: begin
                crc_word = {crc_word[23:0], b};
                sec_count++;
                if (sec_count < eitp_pkg::CRC_BYTES)
                    return 1'b0;
                sec_phase = eitp_pkg::PH_IDLE;
                sec_count = 4'd0;
                rec.record_kind = eitp_pkg::KIND_END;
                rec.check_word  = crc_word;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // one byte beat; called and returning at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic is_start);
        eitp_pkg::t_out_beat rec;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_beat.data_byte  = b;
        i_in_beat.first_byte = is_start;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        if (parse_section_byte(b, is_start, rec)) begin
            expected_records.push_back(rec);
            kind_seen[rec.record_kind]++;
        end
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // first n bytes of the built section, the opening one marked
    task automatic send_prefix(input int n);
        for (int i = 0; i < n; i++)
            send_byte(sec_buf[i], i == 0);
    endtask

    task automatic wait_drain();
        i_in_valid = 1'b0;
        while (expected_records.size() > 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [7:0] fill_byte(input int fill);
        return (fill < 0) ? 8'($urandom) : 8'(fill);
    endfunction

    function automatic logic [7:0] random_table_id();
        int pick;
        pick = $urandom_range(0, 33);
        if (pick == 0)
            return eitp_pkg::TID_PF_ACTUAL;
        if (pick == 1)
            return eitp_pkg::TID_PF_OTHER;
        return eitp_pkg::TID_SCHED_LOW + 8'(pick - 2);
    endfunction

    // build a section into sec_buf; slen_force < 0 takes the true length,
    // fill < 0 gives random content
    function automatic void build_section(input logic [7:0] tid, input int n_events,
                                          input int min_dll, input int max_dll,
                                          input int slen_force, input int fill);
        logic [7:0]  loop_q [$];
        logic [7:0]  tmp;
        logic [11:0] dll;
        logic [11:0] slen;
        loop_q = {};
        for (int i = 0; i < n_events; i++) begin
            dll = 12'($urandom_range(min_dll, max_dll));
            for (int k = 0; k < eitp_pkg::EVENT_BYTES - 2; k++)
                loop_q.push_back(fill_byte(fill));
            tmp = fill_byte(fill);
            loop_q.push_back({tmp[7:4], dll[11:8]});
            loop_q.push_back(dll[7:0]);
            for (int k = 0; k < dll; k++)
                loop_q.push_back(fill_byte(fill));
        end
        slen = (slen_force < 0) ?
               12'(eitp_pkg::LEN_OFFSET + loop_q.size() + eitp_pkg::CRC_BYTES) :
               12'(slen_force);
        sec_buf = {};
        sec_buf.push_back(tid);
        tmp = fill_byte(fill);
        sec_buf.push_back({tmp[7:4], slen[11:8]});
        sec_buf.push_back(slen[7:0]);
        for (int k = 0; k < eitp_pkg::HEAD_BYTES - 3; k++)
            sec_buf.push_back(fill_byte(fill));
        foreach (loop_q[i])
            sec_buf.push_back(loop_q[i]);
        for (int k = 0; k < eitp_pkg::CRC_BYTES; k++)
            sec_buf.push_back(fill_byte(fill));
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // boundary table ids; a good id is dropped by the next marked byte
    task automatic test_table_ids();
        logic [7:0] ids [8] = '{8'h00, 8'h4D, eitp_pkg::TID_PF_ACTUAL,
                                eitp_pkg::TID_PF_OTHER, eitp_pkg::TID_SCHED_LOW,
                                eitp_pkg::TID_SCHED_HIGH, 8'h70, 8'hFF};
        foreach (ids[i])
            send_byte(ids[i], 1'b1);
        // unmarked bytes while idle are ignored
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(eitp_pkg::TID_PF_ACTUAL, 1'b0);
        wait_drain();
    endtask

    // section length below the offset and at the offset plus the crc bytes, crc right after the header
    task automatic test_short_section();
        build_section(eitp_pkg::TID_PF_OTHER, 0, 0, 0, 5, -1);
        send_prefix(sec_buf.size());
        build_section(eitp_pkg::TID_SCHED_LOW, 0, 0, 0, 15, -1);
        send_prefix(sec_buf.size());
        wait_drain();
    endtask

    // all-ones and all-zeros content
    task automatic test_extreme_fields();
        build_section(eitp_pkg::TID_SCHED_HIGH, 1, 0, 0, -1, 8'hFF);
        send_prefix(sec_buf.size());
        build_section(eitp_pkg::TID_PF_ACTUAL, 1, 0, 0, -1, 8'h00);
        send_prefix(sec_buf.size());
        wait_drain();
    endtask

    // event plus descriptors longer than the remaining length
    task automatic test_overrun();
        build_section(random_table_id(), 2, 2, 5,
                      eitp_pkg::LEN_OFFSET + eitp_pkg::CRC_BYTES + 6, -1);
        send_prefix(sec_buf.size());
        wait_drain();
    endtask

    // marked byte mid-section drops the section silently
    task automatic test_restart();
        build_section(random_table_id(), 2, 0, 3, -1, -1);
        send_prefix(7);
        build_section(random_table_id(), 2, 0, 3, -1, -1);
        send_prefix(20);
        build_section(random_table_id(), 2, 0, 3, -1, -1);
        send_prefix(sec_buf.size());
        wait_drain();
    endtask

    // widest descriptor loop length, cut short by the next section start
    task automatic test_long_descriptor();
        build_section(random_table_id(), 1, 4095, 4095, -1, -1);
        send_prefix(eitp_pkg::HEAD_BYTES + eitp_pkg::EVENT_BYTES + DESC_CUT);
        wait_drain();
    endtask

    // output held off for a long stretch while bytes keep coming
    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_left      = HOLD_CYCLES;
        build_section(random_table_id(), 8, 0, 2, -1, -1);
        send_prefix(sec_buf.size());
        wait_drain();
    endtask

    // mostly well formed sections, with broken lengths, cut sections and noise
    task automatic test_random_sections();
        int idle_mix  [4] = '{0, 53, 0, 29};
        int stall_mix [4] = '{0, 0, 53, 29};
        int target;
        int pick;
        logic [7:0] b;
        for (int p = 0; p < 4; p++) begin
            src_idle_pct   = idle_mix[p];
            sink_stall_pct = stall_mix[p];
            target = bytes_sent + RANDOM_BYTES / 4;
            while (bytes_sent < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    build_section(random_table_id(), $urandom_range(0, 6), 0,
                                  ($urandom_range(0, 19) == 0) ? 200 : 12, -1, -1);
                    send_prefix(sec_buf.size());
                end else if (pick < 75) begin
                    build_section(random_table_id(), $urandom_range(0, 4), 0, 8,
                                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                              : $urandom_range(0, 80), -1);
                    send_prefix(sec_buf.size());
                end else if (pick < 85) begin
                    build_section(random_table_id(), $urandom_range(0, 4), 0, 8, -1, -1);
                    send_prefix($urandom_range(1, sec_buf.size() - 1));
                end else if (pick < 95) begin
                    repeat ($urandom_range(1, 8))
                        send_byte(8'($urandom), $urandom_range(0, 7) == 0);
                end else begin
                    do
                        b = 8'($urandom);
                    while (table_id_ok(b));
                    send_byte(b, 1'b1);
                    repeat ($urandom_range(0, 3))
                        send_byte(8'($urandom), 1'b0);
                end
            end
            wait_drain();
        end
    endtask

    // ------------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------------

    // receiver stall, with the long hold-off counted here
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left--;
        end else begin
            i_out_stall = ($urandom_range(0, 99) < sink_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // compare each record beat with the oldest prediction
    always @(posedge i_clk) begin : record_check
        eitp_pkg::t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_records.size() == 0) begin
                $display("%0t: unexpected record, expected none actual %p", $time, o_out_beat);
                errors++;
            end else begin
                want = expected_records.pop_front();
                check_field("record_kind", want.record_kind, o_out_beat.record_kind);
                check_field("ident", want.ident, o_out_beat.ident);
                check_field("version", want.version, o_out_beat.version);
                check_field("section_index", want.section_index, o_out_beat.section_index);
                check_field("stream_ident", want.stream_ident, o_out_beat.stream_ident);
                check_field("network_ident", want.network_ident, o_out_beat.network_ident);
                check_field("start_day", want.start_day, o_out_beat.start_day);
                check_field("start_clock", want.start_clock, o_out_beat.start_clock);
                check_field("length_clock", want.length_clock, o_out_beat.length_clock);
                check_field("run_state", want.run_state, o_out_beat.run_state);
                check_field("conditional_access", want.conditional_access,
                            o_out_beat.conditional_access);
                check_field("check_word", want.check_word, o_out_beat.check_word);
                records_seen++;
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: watchdog, no beat for %0d cycles", $time, quiet);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin : run
        sec_phase     = eitp_pkg::PH_IDLE;
        sec_count     = 4'd0;
        sec_remaining = 12'd0;
        desc_skip     = 12'd0;
        crc_word      = 32'd0;
        i_rst_n       = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        src_idle_pct   = 29;
        sink_stall_pct = 29;
        test_table_ids();
        test_short_section();
        test_extreme_fields();
        test_overrun();
        test_restart();
        test_long_descriptor();
        test_backpressure();
        test_random_sections();

        wait_drain();
        repeat (10) @(posedge i_clk);
        $display("covered %0d section bytes and %0d records:", bytes_sent, records_seen);
        $display("  %0d header, %0d event, %0d end, %0d bad id",
                 kind_seen[eitp_pkg::KIND_HEADER], kind_seen[eitp_pkg::KIND_EVENT],
                 kind_seen[eitp_pkg::KIND_END], kind_seen[eitp_pkg::KIND_BAD_ID]);
        $display("idle and stall mixes, a %0d cycle output hold-off, cut and overrun sections",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
